FILE: design/spq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
`default_nettype none

package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIO_WIDTH    = 2;
   localparam int PAYLOAD_WIDTH = 16;
   localparam int FILL_WIDTH    = 5;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_WIDTH-1:0]    prio;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } entry_type;

   // Broadcast to every cell in the cycle a beat is accepted
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cmd_type;

endpackage

`default_nettype wire

FILE: design/spq_cell.sv
// One slot of the sorted shift chain: holds an entry, shifts or captures it.
`default_nettype none

module spq_cell (
   input  wire                      clock,
   input  wire spq_pkg::cmd_type    cmd,
   input  wire                      occupied,
   input  wire                      prev_gt,
   input  wire spq_pkg::entry_type  prev_entry,
   input  wire spq_pkg::entry_type  next_entry,
   output logic                     gt,
   output spq_pkg::entry_type       entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Entry here ranks behind the incoming one; chain is sorted, so
   // the first such cell is the insertion point.
   assign gt    = occupied && (entry_ff.prio > cmd.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt || !occupied) begin
            entry_in = cmd.item;
         end
      end else if (cmd.deq) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: design/sorted_insert_priority_queue.sv
// Top level: sorted shift-chain priority queue with command-style ports.
// Result strobe is registered and rises in the cycle after the accepting edge.
// Throughput: one command per cycle; every cell compares and shifts in parallel.
// busy is held low, so start is taken in every cycle it is high.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the fill count and result strobe; stored entries need no reset.
`default_nettype none

module sorted_insert_priority_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [0:0]  req_opcode,
   input  wire  [1:0]  req_priority_req,
   input  wire  [15:0] req_payload,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_out_priority,
   output logic [15:0] rsp_out_payload,
   output logic [4:0]  rsp_fill_count
);

   localparam int Depth = spq_pkg::QUEUE_DEPTH;
   localparam int FillW = spq_pkg::FILL_WIDTH;

   logic                   accept;
   logic                   is_enq;
   logic                   full;
   logic                   empty;
   spq_pkg::cmd_type       cmd;
   logic [FillW-1:0]       count_ff;
   logic [FillW-1:0]       count_in;
   logic [Depth-1:0]       occupied;
   logic [Depth-1:0]       gt;
   spq_pkg::entry_type     entries [Depth];

   logic                   rsp_valid_ff;
   spq_pkg::status_type    status_ff;
   spq_pkg::status_type    status_in;
   spq_pkg::entry_type     out_ff;
   spq_pkg::entry_type     out_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_enq = (req_opcode == spq_pkg::OP_ENQ);
   assign full   = (count_ff == FillW'(Depth));
   assign empty  = (count_ff == '0);

   assign cmd.enq          = accept && is_enq && !full;
   assign cmd.deq          = accept && !is_enq && !empty;
   assign cmd.item.prio    = req_priority_req;
   assign cmd.item.payload = req_payload;

   genvar i;
   generate
      for (i = 0; i < Depth; i++) begin : g_cell
         spq_pkg::entry_type prev_e;
         spq_pkg::entry_type next_e;
         logic               prev_g;

         assign occupied[i] = (count_ff > FillW'(i));

         if (i == 0) begin : g_first
            assign prev_g = 1'b0;
            assign prev_e = '0;
         end else begin : g_mid
            assign prev_g = gt[i-1];
            assign prev_e = entries[i-1];
         end

         if (i == Depth - 1) begin : g_last
            assign next_e = '0;
         end else begin : g_body
            assign next_e = entries[i+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occupied[i]),
            .prev_gt    (prev_g),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .gt         (gt[i]),
            .entry      (entries[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::STATUS_OK;
      out_in    = '0;
      if (accept) begin
         if (is_enq) begin
            if (full) begin
               status_in = spq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + FillW'(1);
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - FillW'(1);
               out_in   = entries[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_ff.prio;
   assign rsp_out_payload  = out_ff.payload;
   assign rsp_fill_count   = count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FillW'(Depth))
      else $error("fill count above depth");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && is_enq && full |=> rsp_valid && rsp_status == spq_pkg::STATUS_FULL
         && rsp_fill_count == FillW'(Depth))
      else $error("enqueue on full queue not refused");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY |->
         rsp_out_payload == '0 && rsp_out_priority == '0 && rsp_fill_count == '0)
      else $error("empty dequeue result not cleared");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> count_ff == $past(count_ff) - FillW'(1))
      else $error("dequeue did not drop fill count");
`endif

endmodule

`default_nettype wire
